// ----- rtl/ctfd_pkg.sv -----
// Package for the capacitive touch frequency detector.
// Holds widths, fixed-point constants, the control state type and the shared structs.
// No dependencies; every other file refers to it by scoped names.
package ctfd_pkg;

    localparam int unsigned STAMP_W      = 16;
    localparam int unsigned FREQ_W       = 23;
    localparam int unsigned THR_W        = 23;
    localparam int unsigned SUM_W        = 23;
    localparam int unsigned WINDOW       = 20;
    localparam int unsigned TICK_RATE    = 5000000;
    localparam int unsigned THRESH_RESET = 800;

    // floor(floor(T / d) / W) == floor(floor(T / W) / d), so divide a folded constant
    localparam int unsigned DIVIDEND = TICK_RATE / WINDOW;
    localparam int unsigned DVD_W    = $clog2(DIVIDEND + 1);
    localparam int unsigned SLOT_W   = DVD_W;
    localparam int unsigned IDX_W    = $clog2(WINDOW);
    localparam int unsigned CNT_W    = $clog2(DVD_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [STAMP_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] quotient;
    } t_div_stat;

    typedef struct packed {
        logic              wr;
        logic [SLOT_W-1:0] slot;
    } t_win_req;

endpackage

// ----- rtl/ctfd_if.sv -----
// Valid/ready channel interfaces for capture input, result output and threshold writes.
// Depends on ctfd_pkg for the field widths.
interface ctfd_cap_if;
    logic                          valid;
    logic                          ready;
    logic [ctfd_pkg::STAMP_W-1:0]  capture_stamp;

    modport source (output valid, output capture_stamp, input ready);
    modport sink   (input valid, input capture_stamp, output ready);
endinterface

interface ctfd_res_if;
    logic                          valid;
    logic                          ready;
    logic [ctfd_pkg::FREQ_W-1:0]   average_freq;
    logic                          touched;
    logic                          updated;

    modport source (output valid, output average_freq, output touched, output updated,
                    input ready);
    modport sink   (input valid, input average_freq, input touched, input updated,
                    output ready);
endinterface

interface ctfd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ctfd_pkg::THR_W-1:0]    wdata;

    modport source (output valid, output wdata, input ready);
    modport sink   (input valid, input wdata, output ready);
endinterface

// ----- rtl/ctfd_div.sv -----
// Bit-serial restoring divider: constant dividend over a 16-bit period, one quotient bit a cycle.
// Depends on ctfd_pkg.
module ctfd_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ctfd_pkg::t_div_req  i_req,
    output ctfd_pkg::t_div_stat o_stat
);

    logic                          r_busy;
    logic                          r_done;
    logic [ctfd_pkg::CNT_W-1:0]    r_cnt;
    logic [ctfd_pkg::STAMP_W-1:0]  r_div;
    logic [ctfd_pkg::STAMP_W-1:0]  r_rem;
    logic [ctfd_pkg::DVD_W-1:0]    r_dvd;
    logic [ctfd_pkg::DVD_W-1:0]    r_quo;

    logic [ctfd_pkg::STAMP_W:0]    w_trial;
    logic [ctfd_pkg::STAMP_W:0]    w_sub;
    logic                          w_ge;
    logic [ctfd_pkg::STAMP_W-1:0]  n_rem;
    logic                          w_last;

    always_comb begin
        w_trial = {r_rem, r_dvd[ctfd_pkg::DVD_W-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_sub   = w_trial - {1'b0, r_div};
        // remainder stays below the divisor, so it fits the period width
        n_rem   = w_ge ? w_sub[ctfd_pkg::STAMP_W-1:0] : w_trial[ctfd_pkg::STAMP_W-1:0];
        w_last  = r_cnt == ctfd_pkg::CNT_W'(ctfd_pkg::DVD_W - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.divisor;
            r_rem <= '0;
            r_dvd <= ctfd_pkg::DVD_W'(ctfd_pkg::DIVIDEND);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[ctfd_pkg::DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[ctfd_pkg::DVD_W-2:0], w_ge};
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_quo;

endmodule

// ----- rtl/ctfd_win.sv -----
// Ring of window slots and the running sum over them.
// Depends on ctfd_pkg.
module ctfd_win (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ctfd_pkg::t_win_req          i_req,
    output logic [ctfd_pkg::SUM_W-1:0]  o_sum
);

    logic [ctfd_pkg::SLOT_W-1:0] r_slots [ctfd_pkg::WINDOW];
    logic [ctfd_pkg::IDX_W-1:0]  r_idx;
    logic [ctfd_pkg::SUM_W-1:0]  r_sum;
    logic [ctfd_pkg::SUM_W-1:0]  n_sum;
    logic [ctfd_pkg::IDX_W-1:0]  n_idx;

    always_comb begin
        // add the new slot and drop the one it overwrites
        n_sum = r_sum - ctfd_pkg::SUM_W'(r_slots[r_idx]) + ctfd_pkg::SUM_W'(i_req.slot);
        n_idx = (r_idx == ctfd_pkg::IDX_W'(ctfd_pkg::WINDOW - 1)) ? '0 : r_idx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ctfd_pkg::WINDOW; k++) begin
                r_slots[k] <= '0;
            end
            r_idx <= '0;
            r_sum <= '0;
        end else if (i_req.wr) begin
            r_slots[r_idx] <= i_req.slot;
            r_idx          <= n_idx;
            r_sum          <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- rtl/cap_touch_frequency_detector_core.sv -----
// Flow: a start capture or a discarded pair goes from idle straight to the emit state;
// a valid pair passes through the divide state (18 divider steps) and the window update first.
// Captures are taken only in idle, so the bit-serial 18-step divider and a stalled output
// hold off the next capture; the next capture is taken once the result is stored.
// Reset: synchronous, active low; clears pairing state, slots and sum, threshold to 800.
// Depends on ctfd_pkg, ctfd_if, ctfd_div and ctfd_win.
module cap_touch_frequency_detector_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ctfd_cap_if.sink          i_cap,
    ctfd_cfg_if.sink          i_cfg,
    ctfd_res_if.source        o_res
);

    ctfd_pkg::t_state              r_state;
    ctfd_pkg::t_state              n_state;
    logic                          r_awaiting_end;
    logic [ctfd_pkg::STAMP_W-1:0]  r_start_stamp;
    logic [ctfd_pkg::THR_W-1:0]    r_threshold;
    logic                          r_updated;
    logic                          r_out_valid;
    logic [ctfd_pkg::FREQ_W-1:0]   r_out_avg;
    logic                          r_out_touched;
    logic                          r_out_updated;

    ctfd_pkg::t_div_req            w_div_req;
    ctfd_pkg::t_div_stat           w_div_stat;
    ctfd_pkg::t_win_req            w_win_req;
    logic [ctfd_pkg::SUM_W-1:0]    w_sum;

    logic                          w_accept;
    logic                          w_valid_pair;
    logic                          w_out_free;
    logic                          w_out_load;

    assign w_accept     = i_cap.valid && i_cap.ready;
    assign w_valid_pair = r_awaiting_end && (i_cap.capture_stamp > r_start_stamp);
    assign w_out_free   = !r_out_valid || o_res.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctfd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_valid_pair ? ctfd_pkg::ST_DIV : ctfd_pkg::ST_EMIT;
                end
            end
            ctfd_pkg::ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = ctfd_pkg::ST_UPD;
                end
            end
            ctfd_pkg::ST_UPD: begin
                n_state = ctfd_pkg::ST_EMIT;
            end
            ctfd_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ctfd_pkg::ST_IDLE;
                end
            end
            default: n_state = ctfd_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_cap.ready       = 1'b0;
        w_div_req.start   = 1'b0;
        w_div_req.divisor = i_cap.capture_stamp - r_start_stamp;
        w_win_req.wr      = 1'b0;
        w_win_req.slot    = w_div_stat.quotient;
        w_out_load        = 1'b0;
        unique case (r_state)
            ctfd_pkg::ST_IDLE: begin
                i_cap.ready     = 1'b1;
                w_div_req.start = i_cap.valid && w_valid_pair;
            end
            ctfd_pkg::ST_DIV: begin
            end
            ctfd_pkg::ST_UPD: begin
                w_win_req.wr = 1'b1;
            end
            ctfd_pkg::ST_EMIT: begin
                w_out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ctfd_pkg::ST_IDLE;
            r_awaiting_end <= 1'b0;
            r_start_stamp  <= '0;
            r_threshold    <= ctfd_pkg::THR_W'(ctfd_pkg::THRESH_RESET);
            r_updated      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_threshold <= i_cfg.wdata;
            end
            if (w_accept) begin
                r_updated <= 1'b0;
                if (!r_awaiting_end) begin
                    r_start_stamp  <= i_cap.capture_stamp;
                    r_awaiting_end <= 1'b1;
                end else begin
                    r_awaiting_end <= 1'b0;
                end
            end
            if (w_win_req.wr) begin
                r_updated <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result payload until the transaction completes
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_avg     <= w_sum;
            r_out_touched <= w_sum < r_threshold;
            r_out_updated <= r_updated;
        end
    end

    ctfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_stat  (w_div_stat)
    );

    ctfd_win u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_win_req),
        .o_sum   (w_sum)
    );

    assign i_cfg.ready        = 1'b1;
    assign o_res.valid        = r_out_valid;
    assign o_res.average_freq = r_out_avg;
    assign o_res.touched      = r_out_touched;
    assign o_res.updated      = r_out_updated;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> r_state == ctfd_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    a_win_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_win_req.wr |-> $past(w_div_stat.done))
        else $error("window write without a finished divide");

    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_valid_pair) |=> r_state == ctfd_pkg::ST_EMIT)
        else $error("start or discarded capture did not go straight to emit");

    a_updated_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ctfd_pkg::ST_UPD) |=> (r_state == ctfd_pkg::ST_EMIT && r_updated))
        else $error("window update did not flag the result as updated");

endmodule
